// File: rtl/srb_pkg.sv
// Shared types and constants for the stream reassembly buffer.
`default_nettype none
package srb_pkg;

  localparam int WindowBytesDefault = 1024;
  localparam int OfsW = 62;
  localparam int LimitW = 7;
  localparam int MaxOut = 64;
  localparam int QueueDepth = 2;

  localparam logic [1:0] OP_SUPPLY = 2'd0;
  localparam logic [1:0] OP_FIN    = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_DUPLICATE = 2'd1;
  localparam logic [1:0] ST_CONSUMED  = 2'd2;
  localparam logic [1:0] ST_BEYOND    = 2'd3;

  typedef enum logic [1:0] {
    K_SUPPLY,
    K_FIN,
    K_READ,
    K_NONE
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [OfsW-1:0]   ofs;
    logic [7:0]        data;
    logic [LimitW-1:0] limit;
  } item_t;

endpackage
`default_nettype wire

// File: rtl/srb_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module srb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: rtl/srb_front.sv
// Front end: accepts input items, classifies them and queues them for the back end.
`default_nettype none
module srb_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          clearing,
  input  wire logic          s_tvalid,
  output logic               s_tready,
  input  wire logic [79:0]   s_tdata,
  output logic               head_valid,
  output srb_pkg::item_t     head,
  input  wire logic          pop
);

  localparam int PW = (srb_pkg::QueueDepth > 1) ? $clog2(srb_pkg::QueueDepth) : 1;
  localparam int CW = $clog2(srb_pkg::QueueDepth + 1);

  srb_pkg::item_t q [srb_pkg::QueueDepth];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  srb_pkg::item_t item_in;
  logic           push;
  logic           do_pop;
  logic [1:0]     opcode;
  logic [6:0]     lim;

  assign opcode = s_tdata[1:0];
  assign lim    = s_tdata[78:72];

  always_comb begin
    item_in.ofs   = s_tdata[63:2];
    item_in.data  = s_tdata[71:64];
    item_in.limit = (lim > 7'(srb_pkg::MaxOut)) ? 7'(srb_pkg::MaxOut) : lim;
    unique case (opcode)
      srb_pkg::OP_SUPPLY: item_in.kind = srb_pkg::K_SUPPLY;
      srb_pkg::OP_FIN:    item_in.kind = srb_pkg::K_FIN;
      srb_pkg::OP_READ:   item_in.kind = (lim == 7'd0) ? srb_pkg::K_NONE : srb_pkg::K_READ;
      default:            item_in.kind = srb_pkg::K_NONE;
    endcase
  end

  assign s_tready   = (count != CW'(srb_pkg::QueueDepth)) && !clearing;
  assign push       = s_tvalid && s_tready;
  assign head_valid = (count != '0);
  assign head       = q[rd_ptr];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= item_in;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(srb_pkg::QueueDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(srb_pkg::QueueDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/srb_back.sv
// Back end: window checks, byte storage and the read sequencer with its result register.
`default_nettype none
module srb_back #(
  parameter int WINDOW_BYTES = srb_pkg::WindowBytesDefault
) (
  input  wire logic         clk,
  input  wire logic         rst,
  output logic              clearing,
  input  wire logic         head_valid,
  input  srb_pkg::item_t    head,
  output logic              pop,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [15:0]       m_tdata,
  output logic              m_tuser,
  output logic              m_tlast
);

  localparam int AW = $clog2(WINDOW_BYTES);
  localparam int OW = srb_pkg::OfsW;
  localparam logic [AW:0] WIN = (AW + 1)'(WINDOW_BYTES);

  typedef enum logic [7:0] {
    S_CLEAR    = 8'b0000_0001,
    S_IDLE     = 8'b0000_0010,
    S_SUP_ADDR = 8'b0000_0100,
    S_SUP_CHK  = 8'b0000_1000,
    S_RD_ISSUE = 8'b0001_0000,
    S_RD_CHK   = 8'b0010_0000,
    S_RD_DONE  = 8'b0100_0000,
    S_EMIT     = 8'b1000_0000
  } state_t;

  state_t        state;
  logic [AW-1:0] clr_cnt;
  logic [OW-1:0] read_offset;
  logic [AW-1:0] read_slot;
  logic [OW-1:0] final_size;
  logic          final_known;
  logic [OW-1:0] diff;
  logic          below;
  logic [7:0]    data_r;
  logic [6:0]    limit_r;
  logic [6:0]    cnt;
  logic [AW-1:0] slot_r;
  logic [7:0]    res_byte;
  logic          res_valid;
  logic [1:0]    res_status;
  logic          pend_valid;
  logic [7:0]    pend_byte;
  logic          pend_fin;
  logic          out_byte_valid;
  logic [7:0]    out_byte;
  logic          out_fin;
  logic [1:0]    out_status;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [8:0]    ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [8:0]    ram_rdata;

  logic          out_free;
  logic          out_load;
  logic          fin_now;
  logic          fin_after;
  logic          rd_stop;
  logic [AW:0]   slot_sum;
  logic [AW-1:0] slot_calc;
  logic [AW-1:0] read_slot_inc;

  // Each entry holds a present bit above the stored byte.
  srb_ram #(.WIDTH(9), .DEPTH(WINDOW_BYTES)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign clearing  = (state == S_CLEAR);
  assign out_free  = !m_tvalid || m_tready;
  assign out_load  = out_free && ((state == S_EMIT) || (state == S_RD_DONE) ||
                     ((state == S_RD_CHK) && ram_rdata[8] && pend_valid));
  assign fin_now   = final_known && (read_offset == final_size);
  assign fin_after = final_known && ((read_offset + 1'b1) == final_size);
  assign rd_stop   = fin_now || (read_offset == '1) || (cnt == limit_r);
  assign pop       = (state == S_IDLE) && head_valid;

  assign slot_sum      = {1'b0, read_slot} + {1'b0, diff[AW-1:0]};
  assign slot_calc     = (slot_sum >= WIN) ? AW'(slot_sum - WIN) : slot_sum[AW-1:0];
  assign read_slot_inc = (read_slot == AW'(WINDOW_BYTES - 1)) ? '0 : read_slot + 1'b1;

  assign m_tdata = {5'd0, out_status, out_fin, out_byte};
  assign m_tuser = out_byte_valid;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = '0;
    unique case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt;
      end
      S_SUP_ADDR: begin
        ram_re    = 1'b1;
        ram_raddr = slot_calc;
      end
      S_SUP_CHK: begin
        if (!ram_rdata[8]) begin
          ram_we    = 1'b1;
          ram_waddr = slot_r;
          ram_wdata = {1'b1, data_r};
        end
      end
      S_RD_ISSUE: begin
        ram_re    = !rd_stop;
        ram_raddr = read_slot;
      end
      S_RD_CHK: begin
        if (ram_rdata[8] && (!pend_valid || out_free)) begin
          ram_we    = 1'b1;
          ram_waddr = read_slot;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_cnt     <= '0;
      read_offset <= '0;
      read_slot   <= '0;
      final_size  <= '0;
      final_known <= 1'b0;
      pend_valid  <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == AW'(WINDOW_BYTES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (head_valid) begin
            diff       <= head.ofs - read_offset;
            below      <= head.ofs < read_offset;
            data_r     <= head.data;
            limit_r    <= head.limit;
            cnt        <= '0;
            res_byte   <= '0;
            res_valid  <= 1'b0;
            res_status <= srb_pkg::ST_OK;
            unique case (head.kind)
              srb_pkg::K_SUPPLY: state <= S_SUP_ADDR;
              srb_pkg::K_FIN: begin
                final_size  <= head.ofs;
                final_known <= 1'b1;
                state       <= S_EMIT;
              end
              srb_pkg::K_READ: state <= S_RD_ISSUE;
              default:         state <= S_EMIT;
            endcase
          end
        end
        S_SUP_ADDR: begin
          slot_r <= slot_calc;
          if (below) begin
            res_status <= srb_pkg::ST_CONSUMED;
            state      <= S_EMIT;
          end else if (diff >= OW'(WINDOW_BYTES)) begin
            res_status <= srb_pkg::ST_BEYOND;
            state      <= S_EMIT;
          end else begin
            state <= S_SUP_CHK;
          end
        end
        S_SUP_CHK: begin
          res_status <= ram_rdata[8] ? srb_pkg::ST_DUPLICATE : srb_pkg::ST_OK;
          state      <= S_EMIT;
        end
        S_RD_ISSUE: begin
          state <= rd_stop ? S_RD_DONE : S_RD_CHK;
        end
        S_RD_CHK: begin
          if (!ram_rdata[8]) begin
            state <= S_RD_DONE;
          end else if (!pend_valid || out_free) begin
            // The previous byte is not the last one, since another byte follows.
            if (pend_valid) begin
              out_byte       <= pend_byte;
              out_byte_valid <= 1'b1;
              out_fin        <= pend_fin;
              out_status     <= srb_pkg::ST_OK;
              m_tlast        <= 1'b0;
            end
            pend_valid  <= 1'b1;
            pend_byte   <= ram_rdata[7:0];
            pend_fin    <= fin_after;
            read_offset <= read_offset + 1'b1;
            read_slot   <= read_slot_inc;
            cnt         <= cnt + 1'b1;
            state       <= S_RD_ISSUE;
          end
        end
        S_RD_DONE: begin
          if (out_free) begin
            out_byte       <= pend_valid ? pend_byte : 8'd0;
            out_byte_valid <= pend_valid;
            out_fin        <= pend_valid ? pend_fin : fin_now;
            out_status     <= srb_pkg::ST_OK;
            m_tlast        <= 1'b1;
            pend_valid     <= 1'b0;
            state          <= S_IDLE;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_byte       <= res_byte;
            out_byte_valid <= res_valid;
            out_fin        <= fin_now;
            out_status     <= res_status;
            m_tlast        <= 1'b1;
            state          <= S_IDLE;
          end
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_slot_in_window: assert property (@(posedge clk) disable iff (rst)
    read_slot < AW'(WINDOW_BYTES - 1) || read_slot == AW'(WINDOW_BYTES - 1))
    else $error("read slot left the window");

  a_offset_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (read_offset == $past(read_offset) ||
                     read_offset == $past(read_offset) + 1'b1))
    else $error("read offset moved by more than one byte");

  a_pend_in_read: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> (state == S_RD_ISSUE || state == S_RD_CHK || state == S_RD_DONE))
    else $error("held byte outside a read");

  a_no_pop_while_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !pop)
    else $error("item taken during the clearing pass");
`endif

endmodule
`default_nettype wire

// File: rtl/stream_reassembly_buffer_unit.sv
// Top level of the stream reassembly buffer: front end, item queue and back end.
// After reset all WINDOW_BYTES store entries are cleared; no item is taken meanwhile.
// Fin items go idle to emit; supplies pass a window check, then a store check if inside.
// A read issues and checks each delivered byte in turn, then ends in the done state.
// One item is executed at a time; the two-entry queue keeps accepting while results wait.
// Reset is synchronous and active high.
`default_nettype none
module stream_reassembly_buffer_unit #(
  parameter int WINDOW_BYTES = srb_pkg::WindowBytesDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // opcode[1:0], byte_offset[63:2], data_byte[71:64], read_limit[78:72], zero[79]
  input  wire logic [79:0] s_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // out_byte[7:0], fin_reached[8], status[10:9], zero[15:11]
  output logic [15:0]      m_tdata,
  // byte_valid[0]
  output logic             m_tuser,
  output logic             m_tlast
);

  logic           clearing;
  logic           head_valid;
  srb_pkg::item_t head;
  logic           pop;

  srb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .clearing   (clearing),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  srb_back #(.WINDOW_BYTES(WINDOW_BYTES)) u_back (
    .clk        (clk),
    .rst        (rst),
    .clearing   (clearing),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast)
  );

endmodule
`default_nettype wire

// File: test/tb_stream_reassembly_buffer_unit.sv
// Self-checking testbench for the stream reassembly buffer: directed table, then random traffic.
`default_nettype none
module tb_stream_reassembly_buffer_unit;

  localparam int Window = 1024;
  localparam logic [srb_pkg::OfsW-1:0] OfsTop = {srb_pkg::OfsW{1'b1}};

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       fin_reached;
    logic [1:0] status;
    logic       last;
  } result_t;

  typedef struct {
    logic [1:0]                 op;
    logic [srb_pkg::OfsW-1:0]   ofs;
    logic [7:0]                 data;
    logic [srb_pkg::LimitW-1:0] limit;
    bit                         has_known;
    result_t                    known;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [79:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic m_tuser;
  logic m_tlast;

  stream_reassembly_buffer_unit #(.WINDOW_BYTES(Window)) DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast)
  );

  always #4 clk = ~clk;

  // Predictor state.
  logic [7:0]               win_data [Window];
  bit                       win_valid [Window];
  logic [srb_pkg::OfsW-1:0] next_read;
  logic [srb_pkg::OfsW-1:0] stream_end;
  bit                       end_known;

  result_t pending_results[$];
  int mismatch_count = 0;
  int idle_cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit timed_out = 1'b0;

  function automatic bit at_end();
    return end_known && next_read == stream_end;
  endfunction

  function automatic void predict_item(logic [1:0] op, logic [srb_pkg::OfsW-1:0] ofs,
                                       logic [7:0] data,
                                       logic [srb_pkg::LimitW-1:0] limit);
    result_t r;
    int lim;
    int n;
    int slot;
    n = 0;
    r = '0;
    r.last = 1'b1;
    if (op == srb_pkg::OP_SUPPLY) begin
      slot = int'(ofs % Window);
      if (ofs < next_read) r.status = srb_pkg::ST_CONSUMED;
      else if (ofs - next_read >= Window) r.status = srb_pkg::ST_BEYOND;
      else if (win_valid[slot]) r.status = srb_pkg::ST_DUPLICATE;
      else begin
        win_data[slot] = data;
        win_valid[slot] = 1'b1;
        r.status = srb_pkg::ST_OK;
      end
      r.fin_reached = at_end();
      pending_results.push_back(r);
      return;
    end
    if (op == srb_pkg::OP_FIN) begin
      stream_end = ofs;
      end_known = 1'b1;
      r.fin_reached = at_end();
      pending_results.push_back(r);
      return;
    end
    if (op == srb_pkg::OP_READ) begin
      lim = (limit > srb_pkg::MaxOut) ? srb_pkg::MaxOut : int'(limit);
      while (n < lim && !at_end() && next_read != OfsTop &&
             win_valid[int'(next_read % Window)]) begin
        slot = int'(next_read % Window);
        r = '0;
        r.out_byte = win_data[slot];
        r.byte_valid = 1'b1;
        win_valid[slot] = 1'b0;
        next_read = next_read + 1'b1;
        r.fin_reached = at_end();
        r.last = (n == lim - 1) || at_end() || next_read == OfsTop ||
                 !win_valid[int'(next_read % Window)];
        pending_results.push_back(r);
        n++;
      end
      if (n > 0) return;
    end
    r = '0;
    r.last = 1'b1;
    r.fin_reached = at_end();
    pending_results.push_back(r);
  endfunction

  function automatic void report_mismatch(string what, result_t exp_r, result_t act_r);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("mismatch %s: expected byte=%h valid=%b fin=%b status=%0d last=%b",
               what, exp_r.out_byte, exp_r.byte_valid, exp_r.fin_reached, exp_r.status,
               exp_r.last);
      $display("  got byte=%h valid=%b fin=%b status=%0d last=%b",
               act_r.out_byte, act_r.byte_valid, act_r.fin_reached, act_r.status,
               act_r.last);
    end
  endfunction

  // Result checker and idle counter at the rising edge; the stall generator uses the falling edge.
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (m_tvalid && m_tready) begin
        got.out_byte = m_tdata[7:0];
        got.fin_reached = m_tdata[8];
        got.status = m_tdata[10:9];
        got.byte_valid = m_tuser;
        got.last = m_tlast;
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result", '0, got);
        end else begin
          want = pending_results.pop_front();
          if (got != want) report_mismatch("field", want, got);
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Expected results typed in from the model where obvious; 'has_known' marks such rows.
  function automatic result_t rk(logic [7:0] b, logic v, logic f, logic [1:0] st, logic l);
    result_t r;
    r.out_byte = b; r.byte_valid = v; r.fin_reached = f; r.status = st; r.last = l;
    return r;
  endfunction

  // Presents one item from the next falling edge and returns at the edge that accepts it.
  task automatic send_item(logic [1:0] op, logic [srb_pkg::OfsW-1:0] ofs,
                           logic [7:0] data, logic [srb_pkg::LimitW-1:0] limit);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tdata <= {1'b0, limit, data, ofs, op};
    s_tvalid <= 1'b1;
    predict_item(op, ofs, data, limit);
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic run_random(int count);
    int kind;
    logic [srb_pkg::OfsW-1:0] ofs;
    for (int i = 0; i < count; i++) begin
      kind = $urandom_range(99);
      if (kind < 60) begin
        // Mostly offsets just ahead of the read point, some far away.
        if ($urandom_range(9) < 8) ofs = next_read + $urandom_range(40);
        else if ($urandom_range(1)) ofs = next_read + Window - 2 + $urandom_range(4);
        else ofs = srb_pkg::OfsW'({$urandom, $urandom});
        if ($urandom_range(9) == 0 && next_read > 0) ofs = next_read - 1;
        send_item(srb_pkg::OP_SUPPLY, ofs, 8'($urandom), 7'($urandom));
      end else if (kind < 66) begin
        send_item(srb_pkg::OP_FIN, next_read + $urandom_range(60), 8'($urandom),
                  7'($urandom));
      end else if (kind < 68) begin
        send_item(2'd3, srb_pkg::OfsW'({$urandom, $urandom}), 8'($urandom), 7'($urandom));
      end else begin
        send_item(srb_pkg::OP_READ, srb_pkg::OfsW'({$urandom, $urandom}), 8'($urandom),
                  ($urandom_range(9) == 0) ? 7'($urandom) : 7'($urandom_range(1, 20)));
      end
    end
  endtask

  initial begin
    stim_row_t rows[$];
    stim_row_t row;
    for (int i = 0; i < Window; i++) begin
      win_valid[i] = 1'b0;
      win_data[i] = '0;
    end
    next_read = '0;
    stream_end = '0;
    end_known = 1'b0;

    // Directed table: op, offset, data, limit, typed-in flag, typed-in result.
    rows.push_back('{srb_pkg::OP_READ,   62'd0,    8'h00, 7'd5,   1,
                     rk(8'h00, 0, 0, srb_pkg::ST_OK, 1)});
    rows.push_back('{srb_pkg::OP_SUPPLY, 62'd0,    8'hFF, 7'd0,   1,
                     rk(8'h00, 0, 0, srb_pkg::ST_OK, 1)});
    rows.push_back('{srb_pkg::OP_SUPPLY, 62'd0,    8'h11, 7'd0,   1,
                     rk(8'h00, 0, 0, srb_pkg::ST_DUPLICATE, 1)});
    rows.push_back('{srb_pkg::OP_SUPPLY, 62'd1024, 8'h22, 7'd0,   1,
                     rk(8'h00, 0, 0, srb_pkg::ST_BEYOND, 1)});
    rows.push_back('{srb_pkg::OP_SUPPLY, OfsTop,   8'h00, 7'h7F,  1,
                     rk(8'h00, 0, 0, srb_pkg::ST_BEYOND, 1)});
    rows.push_back('{srb_pkg::OP_SUPPLY, 62'd1023, 8'hA5, 7'd0,   0, '0});
    rows.push_back('{srb_pkg::OP_SUPPLY, 62'd1,    8'h5A, 7'd0,   0, '0});
    rows.push_back('{srb_pkg::OP_READ,   62'd0,    8'h00, 7'd0,   1,
                     rk(8'h00, 0, 0, srb_pkg::ST_OK, 1)});
    rows.push_back('{srb_pkg::OP_READ,   62'd0,    8'h00, 7'd127, 0, '0});
    rows.push_back('{srb_pkg::OP_SUPPLY, 62'd0,    8'h33, 7'd0,   1,
                     rk(8'h00, 0, 0, srb_pkg::ST_CONSUMED, 1)});
    rows.push_back('{2'd3,               OfsTop,   8'hFF, 7'h7F,  1,
                     rk(8'h00, 0, 0, srb_pkg::ST_OK, 1)});
    rows.push_back('{srb_pkg::OP_FIN,    62'd4,    8'h00, 7'd0,   0, '0});
    rows.push_back('{srb_pkg::OP_FIN,    62'd2,    8'h00, 7'd0,   0, '0});
    rows.push_back('{srb_pkg::OP_SUPPLY, 62'd2,    8'h44, 7'd0,   0, '0});
    rows.push_back('{srb_pkg::OP_SUPPLY, 62'd3,    8'h55, 7'd0,   0, '0});
    rows.push_back('{srb_pkg::OP_READ,   62'd0,    8'h00, 7'd64,  0, '0});
    rows.push_back('{srb_pkg::OP_FIN,    62'd100,  8'h00, 7'd0,   0, '0});
    rows.push_back('{srb_pkg::OP_READ,   62'd0,    8'h00, 7'd1,   0, '0});
    rows.push_back('{srb_pkg::OP_READ,   62'd0,    8'h00, 7'd65,  0, '0});

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (rows[i]) begin
      row = rows[i];
      send_item(row.op, row.ofs, row.data, row.limit);
      if (row.has_known && pending_results.size() != 0 &&
          pending_results[$] != row.known)
        report_mismatch("table row", row.known, pending_results[$]);
    end
    // The sender holds off here until every result is back.
    drain();

    // Fill a run of bytes and read it out with the largest limit.
    for (int i = 0; i < 30; i++) begin
      send_item(srb_pkg::OP_SUPPLY, next_read + i, 8'($urandom), 7'd0);
    end
    send_item(srb_pkg::OP_READ, '0, '0, 7'd64);
    send_item(srb_pkg::OP_READ, '0, '0, 7'd64);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
        default: begin send_idle_pct = 7; recv_stall_pct = 7; end
      endcase
      run_random(18);
    end

    drain();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (200) @(negedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0 && !timed_out) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog: covers the clearing pass after reset and the longest stall.
  initial begin
    wait (idle_cycles >= 20000);
    timed_out = 1'b1;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// File: files.f
rtl/srb_pkg.sv
rtl/srb_ram.sv
rtl/srb_front.sv
rtl/srb_back.sv
rtl/stream_reassembly_buffer_unit.sv
test/tb_stream_reassembly_buffer_unit.sv
